// File: hdl/port_histogram_top_k_unit_defines.svh
// ----------------------------------------------------------------------------
// Port histogram top-k unit: assertion macros
// Checks are built in simulation and drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PORT_HISTOGRAM_TOP_K_UNIT_DEFINES_SVH
`define PORT_HISTOGRAM_TOP_K_UNIT_DEFINES_SVH

`ifndef SYNTH
`define PHTK_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phtk check failed");
`define PHTK_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phtk check failed");
`else
`define PHTK_ASSERT_IMP(label, clk, rst, ante, cons)
`define PHTK_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/phtk_pkg.sv
// ----------------------------------------------------------------------------
// phtk_pkg
// Shared widths, codes and payload types of the port histogram top-k unit.
// ----------------------------------------------------------------------------
package phtk_pkg;

  localparam int DEF_NUM_PORTS = 1024;
  localparam int DEF_TOP_MAX   = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int ACTION_W   = 2;
  localparam int PORT_W     = 16;
  localparam int KIND_W     = 2;
  localparam int RANK_W     = 3;
  localparam int EPORT_W    = 10;
  localparam int COUNT_W    = 32;
  localparam int TOTAL_W    = 42;
  localparam int PIU_W      = 11;
  localparam int TLIM_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TOP    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TOTAL  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PORTS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_LIMIT    = 1'd1;

  localparam logic [PIU_W-1:0]  PIU_RESET  = 11'd1024;
  localparam logic [TLIM_W-1:0] TLIM_RESET = 4'd8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PORT_W-1:0]   port;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [RANK_W-1:0]  entry_rank;
    logic [EPORT_W-1:0] entry_port;
    logic [COUNT_W-1:0] entry_count;
    logic [TOTAL_W-1:0] total_count;
    logic               last;
  } out_t;

  typedef enum logic [1:0] {
    CMD_REC,
    CMD_TOP,
    CMD_TOT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [PORT_W-1:0] port;
  } cmd_t;

endpackage

// File: hdl/port_histogram_top_k_unit.sv
// ----------------------------------------------------------------------------
// port_histogram_top_k_unit
// Saturating per-port access histogram with top-k and total reports.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  input    | in_valid, in_stall, in_data      | items in, stall out
//  output   | out_valid, out_stall, out_data   | results out, stall in
//  config   | cfg_we, cfg_index, cfg_data      | register writes in
//
//  A record item is handled in the back end as a counter read, then a write.
//  A report leaves the queue, then walks the counter memory one port per
//  cycle over ports_in_use ports (capped at NUM_PORTS), then gives one
//  result per cycle while the output is not stalled.
//  After reset a clearing pass zeroes all NUM_PORTS counters; no item is
//  taken meanwhile. A two-entry queue lets input keep flowing while the
//  output is stalled, until the queue fills.
// ----------------------------------------------------------------------------
module port_histogram_top_k_unit import phtk_pkg::*; #(
  parameter int NUM_PORTS = DEF_NUM_PORTS,
  parameter int TOP_MAX   = DEF_TOP_MAX
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(NUM_PORTS + 1);
  localparam int LIM_W = $clog2(TOP_MAX + 1);

  logic             clearing;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  cmd_t             q_cmd;
  cmd_t             q_head;
  logic [CNT_W-1:0] active_ports;
  logic [LIM_W-1:0] lim;

  phtk_front #(
    .NUM_PORTS(NUM_PORTS),
    .TOP_MAX  (TOP_MAX)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .clearing    (clearing),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd),
    .active_ports(active_ports),
    .lim         (lim)
  );

  phtk_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  phtk_back #(
    .NUM_PORTS(NUM_PORTS),
    .TOP_MAX  (TOP_MAX)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .active_ports(active_ports),
    .lim         (lim),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: hdl/phtk_fifo.sv
// ----------------------------------------------------------------------------
// phtk_fifo
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`include "port_histogram_top_k_unit_defines.svh"

module phtk_fifo import phtk_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == FILL_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_cmd;
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `PHTK_ASSERT_IMP(a_no_push_full, clk, rst, push, !full)
  `PHTK_ASSERT_IMP(a_no_pop_empty, clk, rst, pop, !empty)
  `PHTK_ASSERT_NXT(a_push_fills, clk, rst, push && !pop, !empty)

endmodule

// File: hdl/phtk_front.sv
// ----------------------------------------------------------------------------
// phtk_front
// Holds the configuration, classifies input items and queues commands.
// ----------------------------------------------------------------------------
module phtk_front import phtk_pkg::*; #(
  parameter int NUM_PORTS = DEF_NUM_PORTS,
  parameter int TOP_MAX   = DEF_TOP_MAX,
  localparam int CNT_W    = $clog2(NUM_PORTS + 1),
  localparam int LIM_W    = $clog2(TOP_MAX + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  clearing,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  output logic [CNT_W-1:0]      active_ports,
  output logic [LIM_W-1:0]      lim
);

  localparam int CMP_W = (CNT_W > PIU_W) ? CNT_W : PIU_W;
  localparam int PC_W  = (CNT_W > PORT_W) ? CNT_W : PORT_W;
  localparam int LC_W  = (LIM_W > TLIM_W) ? LIM_W : TLIM_W;

  logic [PIU_W-1:0]  ports_in_use;
  logic [TLIM_W-1:0] top_limit;
  logic              keep;
  logic              accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      ports_in_use <= PIU_RESET;
      top_limit    <= TLIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PORTS_IN_USE: ports_in_use <= cfg_data[PIU_W-1:0];
        REG_TOP_LIMIT:    top_limit    <= cfg_data[TLIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign active_ports = (CMP_W'(ports_in_use) > CMP_W'(NUM_PORTS)) ?
                        CNT_W'(NUM_PORTS) : CNT_W'(ports_in_use);
  assign lim = (LC_W'(top_limit) > LC_W'(TOP_MAX)) ? LIM_W'(TOP_MAX) : LIM_W'(top_limit);

  // Classify: drop unknown actions and records of ports out of use
  always_comb begin
    keep       = 1'b0;
    q_cmd.op   = CMD_REC;
    q_cmd.port = in_data.port;
    unique case (in_data.action)
      ACT_RECORD: begin
        q_cmd.op = CMD_REC;
        keep     = PC_W'(in_data.port) < PC_W'(active_ports);
      end
      ACT_TOP: begin
        q_cmd.op = CMD_TOP;
        keep     = 1'b1;
      end
      ACT_TOTAL: begin
        q_cmd.op = CMD_TOT;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall = q_full || clearing;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && keep;

endmodule

// File: hdl/phtk_back.sv
// ----------------------------------------------------------------------------
// phtk_back
// Zeroes the counter memory after reset, then runs queued commands on it:
// counter updates, top-k scans with a parallel insertion list and total scans.
// ----------------------------------------------------------------------------
`include "port_histogram_top_k_unit_defines.svh"

module phtk_back import phtk_pkg::*; #(
  parameter int NUM_PORTS = DEF_NUM_PORTS,
  parameter int TOP_MAX   = DEF_TOP_MAX,
  localparam int CNT_W    = $clog2(NUM_PORTS + 1),
  localparam int LIM_W    = $clog2(TOP_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             q_head,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic [CNT_W-1:0] active_ports,
  input  logic [LIM_W-1:0] lim,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data
);

  localparam int ADDR_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int IDX_W  = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REC,
    ST_SCAN,
    ST_EMIT,
    ST_TOTAL
  } state_t;

  state_t state;

  logic [COUNT_W-1:0] mem [NUM_PORTS];
  logic [COUNT_W-1:0] rd_data;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [COUNT_W-1:0] mem_wd;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_ra;

  logic [ADDR_W-1:0]  rec_addr;
  logic [CNT_W-1:0]   scan_cnt;
  logic               rd_pend;
  logic [ADDR_W-1:0]  rd_port;
  logic               is_top;
  logic [TOTAL_W-1:0] acc;
  logic [TOTAL_W:0]   acc_sum;
  logic [LIM_W-1:0]   filled;
  logic [IDX_W-1:0]   emit_idx;
  logic               emit_last;
  logic               out_free;
  logic               out_load;

  logic [COUNT_W-1:0] best_cnt  [TOP_MAX];
  logic [ADDR_W-1:0]  best_port [TOP_MAX];
  logic [COUNT_W-1:0] new_cnt   [TOP_MAX];
  logic [ADDR_W-1:0]  new_port  [TOP_MAX];
  logic [TOP_MAX-1:0] gt;
  logic [TOP_MAX-1:0] ins;
  logic [TOP_MAX-1:0] ins_ok;
  logic [TOP_MAX-1:0] ins_we;
  logic               take;

  // Counter memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // Insertion list: one compare per slot, shift down from the insert point
  for (genvar j = 0; j < TOP_MAX; j++) begin : g_slot
    assign gt[j]     = (LIM_W'(j) < filled) && (rd_data > best_cnt[j]);
    assign ins[j]    = gt[j] || (LIM_W'(j) == filled);
    assign ins_ok[j] = ins[j] && (LIM_W'(j) < lim);
    assign ins_we[j] = take && ins_ok[j];
    if (j == 0) begin : g_head
      assign new_cnt[j]  = rd_data;
      assign new_port[j] = rd_port;
    end else begin : g_rest
      assign new_cnt[j]  = ins[j-1] ? best_cnt[j-1]  : rd_data;
      assign new_port[j] = ins[j-1] ? best_port[j-1] : rd_port;
    end
  end

  assign take      = rd_pend && is_top && (rd_data != '0) && (|ins_ok);
  assign acc_sum   = {1'b0, acc} + (TOTAL_W + 1)'(rd_data);
  assign emit_last = (LIM_W'(emit_idx) + LIM_W'(1)) == filled;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && ((state == ST_EMIT) || (state == ST_TOTAL));
  assign clearing  = (state == ST_CLEAR);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = rec_addr;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = scan_cnt[ADDR_W-1:0];
    q_pop  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = scan_cnt[ADDR_W-1:0];
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.op == CMD_REC) begin
            mem_re = 1'b1;
            mem_ra = q_head.port[ADDR_W-1:0];
          end
        end
      end
      ST_REC: begin
        mem_we = 1'b1;
        mem_wd = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
      end
      ST_SCAN: begin
        mem_re = (scan_cnt < active_ports);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan_cnt  <= '0;
      rd_pend   <= 1'b0;
      filled    <= '0;
      is_top    <= 1'b0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (scan_cnt == CNT_W'(NUM_PORTS - 1)) begin
            scan_cnt <= '0;
            state    <= ST_IDLE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            scan_cnt <= '0;
            rd_pend  <= 1'b0;
            filled   <= '0;
            acc      <= '0;
            emit_idx <= '0;
            unique case (q_head.op)
              CMD_REC: begin
                rec_addr <= q_head.port[ADDR_W-1:0];
                state    <= ST_REC;
              end
              CMD_TOP: begin
                is_top <= 1'b1;
                state  <= ST_SCAN;
              end
              CMD_TOT: begin
                is_top <= 1'b0;
                state  <= ST_SCAN;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_REC: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_cnt < active_ports) begin
            scan_cnt <= scan_cnt + 1'b1;
            rd_port  <= scan_cnt[ADDR_W-1:0];
            rd_pend  <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && !is_top) begin
            acc <= acc_sum[TOTAL_W] ? TOTAL_MAX : acc_sum[TOTAL_W-1:0];
          end
          for (int k = 0; k < TOP_MAX; k++) begin
            if (ins_we[k]) begin
              best_cnt[k]  <= new_cnt[k];
              best_port[k] <= new_port[k];
            end
          end
          if (take && (filled < lim)) begin
            filled <= filled + 1'b1;
          end
          if ((scan_cnt == active_ports) && !rd_pend) begin
            state <= is_top ? ST_EMIT : ST_TOTAL;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data.total_count <= '0;
            if (filled == '0) begin
              out_data.result_kind <= KIND_EMPTY;
              out_data.entry_rank  <= '0;
              out_data.entry_port  <= '0;
              out_data.entry_count <= '0;
              out_data.last        <= 1'b1;
              state                <= ST_IDLE;
            end else begin
              out_data.result_kind <= KIND_ENTRY;
              out_data.entry_rank  <= RANK_W'(emit_idx);
              out_data.entry_port  <= EPORT_W'(best_port[emit_idx]);
              out_data.entry_count <= best_cnt[emit_idx];
              out_data.last        <= emit_last;
              emit_idx             <= emit_idx + 1'b1;
              if (emit_last) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_TOTAL: begin
          if (out_free) begin
            out_data.result_kind <= KIND_TOTAL;
            out_data.entry_rank  <= '0;
            out_data.entry_port  <= '0;
            out_data.entry_count <= '0;
            out_data.total_count <= acc;
            out_data.last        <= 1'b1;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PHTK_ASSERT_IMP(a_fill_bound, clk, rst, state == ST_SCAN, filled <= lim)
  `PHTK_ASSERT_IMP(a_write_owner, clk, rst, mem_we, state == ST_CLEAR || state == ST_REC)
  `PHTK_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, state == ST_IDLE && !q_empty)

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: port histogram top-k unit
// Sends record, top, total and unknown-action items through the unit under
// random input gaps and output stalls, over several register settings. Some
// directed items carry their report; a local histogram keeping the expected
// counters produces the rest; each is compared field by field with the output.
// ----------------------------------------------------------------------------
module tb;
  import phtk_pkg::*;

  localparam int NPORTS       = DEF_NUM_PORTS;
  localparam int TOPN         = DEF_TOP_MAX;
  localparam int HIST_AW      = $clog2(NPORTS);
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 1200000;
  localparam int RANDOM_ITEMS = 280;
  localparam int NUM_PHASES   = 10;
  localparam int MAX_SHOWN    = 10;

  // action code the unit must ignore
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  port_histogram_top_k_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the counters and registers
  logic [COUNT_W-1:0] hist_counts [NPORTS];
  logic [PIU_W-1:0]   piu_now  = PIU_RESET;
  logic [TLIM_W-1:0]  tlim_now = TLIM_RESET;
  out_t               report_q [$];

  int mismatches = 0;
  int cycles     = 0;
  int stall_left = 0;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;
  out_t want_now;

  int phase_piu  [NUM_PHASES] = '{16, 1, 5, 0, 2047, 40, 12, 1024, 3, 200};
  int phase_tlim [NUM_PHASES] = '{8, 1, 3, 8, 15, 0, 4, 8, 9, 2};

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    int                   reg_val;
    in_t                  item;
    bit                   typed;
    out_t                 want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic out_t empty_report();
    out_t r = '0;
    r.result_kind = KIND_EMPTY;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic out_t total_report(logic [TOTAL_W-1:0] sum);
    out_t r = '0;
    r.result_kind = KIND_TOTAL;
    r.total_count = sum;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int active_ports();
    return (piu_now > NPORTS) ? NPORTS : int'(piu_now);
  endfunction

  function automatic plan_row_t item_row(logic [ACTION_W-1:0] act, int port);
    plan_row_t r;
    r.is_write = 1'b0;
    r.reg_idx = '0;
    r.reg_val = 0;
    r.item.action = act;
    r.item.port = port[PORT_W-1:0];
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic [ACTION_W-1:0] act, out_t want);
    plan_row_t r;
    r = item_row(act, 0);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] idx, int val);
    plan_row_t r;
    r = item_row(ACT_RECORD, 0);
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Apply one item to the local histogram and queue the reports it causes.
  task automatic histogram_step(input in_t it);
    int n, lim, best_p, filled, k, p;
    logic [COUNT_W-1:0] best_c;
    logic [63:0] sum;
    logic [HIST_AW-1:0] hp;
    bit picked [NPORTS];
    int rank_port [TOPN];
    logic [COUNT_W-1:0] rank_cnt [TOPN];
    out_t r;
    n = active_ports();
    case (it.action)
      ACT_RECORD: begin
        hp = it.port[HIST_AW-1:0];
        if (int'(it.port) < n && hist_counts[hp] != COUNT_MAX)
          hist_counts[hp] = hist_counts[hp] + 1'b1;
      end
      ACT_TOP: begin
        lim = (tlim_now > TOPN) ? TOPN : int'(tlim_now);
        filled = 0;
        for (p = 0; p < NPORTS; p++) picked[p] = 1'b0;
        // pick the busiest unpicked port per rank; strict compare keeps the lower port on ties
        for (k = 0; k < lim; k++) begin
          best_p = -1;
          best_c = '0;
          for (p = 0; p < n; p++) begin
            if (!picked[p] && hist_counts[p] > best_c) begin
              best_c = hist_counts[p];
              best_p = p;
            end
          end
          if (best_p >= 0) begin
            picked[best_p] = 1'b1;
            rank_port[filled] = best_p;
            rank_cnt[filled] = best_c;
            filled++;
          end
        end
        if (filled == 0) begin
          report_q.push_back(empty_report());
        end else begin
          for (k = 0; k < filled; k++) begin
            r = '0;
            r.result_kind = KIND_ENTRY;
            r.entry_rank = k[RANK_W-1:0];
            r.entry_port = rank_port[k][EPORT_W-1:0];
            r.entry_count = rank_cnt[k];
            r.last = (k == filled - 1);
            report_q.push_back(r);
          end
        end
      end
      ACT_TOTAL: begin
        sum = '0;
        for (p = 0; p < n; p++) sum += hist_counts[p];
        if (sum > TOTAL_MAX) sum = TOTAL_MAX;
        report_q.push_back(total_report(sum[TOTAL_W-1:0]));
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input in_t it, input bit typed, input out_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // transfer done at this edge
    if (typed) begin
      report_q.push_back(want);
    end else begin
      histogram_step(it);
    end
  endtask

  // Wait for all reports, then let pending record updates finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PORTS_IN_USE) piu_now = val[PIU_W-1:0];
    else tlim_now = val[TLIM_W-1:0];
  endtask

  // Output side: check each transfer, then draw the stall before the next one.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result: kind %0d rank %0d port %0d count %0d total %0d",
                     out_data.result_kind, out_data.entry_rank, out_data.entry_port,
                     out_data.entry_count, out_data.total_count);
        end else begin
          want_now = report_q.pop_front();
          if (out_data.result_kind !== want_now.result_kind ||
              out_data.entry_rank !== want_now.entry_rank ||
              out_data.entry_port !== want_now.entry_port ||
              out_data.entry_count !== want_now.entry_count ||
              out_data.total_count !== want_now.total_count ||
              out_data.last !== want_now.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("mismatch: expected kind %0d rank %0d port %0d count %0d",
                       want_now.result_kind, want_now.entry_rank, want_now.entry_port,
                       want_now.entry_count, " total %0d last %0d;",
                       want_now.total_count, want_now.last,
                       " got kind %0d rank %0d port %0d count %0d",
                       out_data.result_kind, out_data.entry_rank, out_data.entry_port,
                       out_data.entry_count, " total %0d last %0d",
                       out_data.total_count, out_data.last);
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, 11);
      end
      // long hold-off so the unit fills up and stalls its input
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    plan_row_t row;
    in_t it;
    int ph, taken, pick, sel, span;
    int hot [6];

    foreach (hist_counts[p]) hist_counts[p] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part, starting from reset settings
    plan.push_back(typed_row(ACT_TOTAL, total_report('0)));
    plan.push_back(typed_row(ACT_TOP, empty_report()));
    plan.push_back(item_row(ACT_RECORD, 0));
    plan.push_back(item_row(ACT_RECORD, 0));
    plan.push_back(item_row(ACT_RECORD, NPORTS - 1));
    plan.push_back(item_row(ACT_RECORD, NPORTS));
    plan.push_back(item_row(ACT_RECORD, 65535));
    plan.push_back(item_row(ACT_UNUSED, 0));
    plan.push_back(typed_row(ACT_TOTAL, total_report(TOTAL_W'(3))));
    plan.push_back(item_row(ACT_TOP, 0));
    plan.push_back(item_row(ACT_RECORD, 5));
    plan.push_back(item_row(ACT_RECORD, 5));
    plan.push_back(item_row(ACT_RECORD, NPORTS - 1));
    plan.push_back(item_row(ACT_TOP, 0));
    plan.push_back(write_row(REG_TOP_LIMIT, 0));
    plan.push_back(typed_row(ACT_TOP, empty_report()));
    plan.push_back(write_row(REG_TOP_LIMIT, 15));
    plan.push_back(write_row(REG_PORTS_IN_USE, 2047));
    plan.push_back(item_row(ACT_TOP, 65535));
    plan.push_back(write_row(REG_PORTS_IN_USE, 5));
    plan.push_back(item_row(ACT_TOTAL, 0));
    plan.push_back(write_row(REG_PORTS_IN_USE, 0));
    plan.push_back(typed_row(ACT_TOTAL, total_report('0)));
    plan.push_back(typed_row(ACT_TOP, empty_report()));
    plan.push_back(item_row(ACT_RECORD, 0));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_write) write_reg(row.reg_idx, row.reg_val);
      else send_item(row.item, row.typed, row.want);
    end

    // random part: mostly records on a few hot ports, with reports mixed in
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(REG_PORTS_IN_USE, phase_piu[ph]);
      write_reg(REG_TOP_LIMIT, phase_tlim[ph]);
      span = active_ports();
      calm = ($urandom_range(0, 3) == 0);
      if (ph == 2) hold_req <= 1'b1;
      foreach (hot[k]) hot[k] = (span == 0) ? 0 : $urandom_range(0, span - 1);
      taken = 0;
      while (taken < RANDOM_ITEMS / NUM_PHASES) begin
        pick = $urandom_range(0, 99);
        it.port = PORT_W'($urandom_range(0, 65535));
        if (pick < 72) begin
          it.action = ACT_RECORD;
          sel = $urandom_range(0, 99);
          if (span > 0 && sel < 50) it.port = PORT_W'(hot[$urandom_range(0, 5)]);
          else if (span > 0 && sel < 85) it.port = PORT_W'($urandom_range(0, span - 1));
          else if (sel < 92) it.port = PORT_W'(span);
        end else if (pick < 84) begin
          it.action = ACT_TOP;
        end else if (pick < 95) begin
          it.action = ACT_TOTAL;
        end else begin
          it.action = ACT_UNUSED;
        end
        send_item(it, 1'b0, '0);
        taken++;
      end
    end

    settle();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/phtk_pkg.sv
hdl/phtk_fifo.sv
hdl/phtk_front.sv
hdl/phtk_back.sv
hdl/port_histogram_top_k_unit.sv
bench/tb.sv
